// ===== design/iss_pkg.sv =====
// Shared constants and types for the indexed sequential search block.
// Holds the store geometry, derived widths and controller/datapath structs.
// No dependencies.
`default_nettype none

package iss_pkg;

    localparam int PAGE_COUNT   = 256;
    localparam int PAGE_ITEMS   = 4;
    localparam int PAYLOAD_BITS = 32;

    localparam int STORE_DEPTH  = PAGE_COUNT * PAGE_ITEMS;
    localparam int KEY_W        = 32;
    localparam int POS_W        = 10;
    localparam int COUNT_W      = 11;
    localparam int PROBE_W      = 9;
    localparam int PAGE_AW      = $clog2(PAGE_COUNT);
    localparam int SLOT_W       = $clog2(PAGE_ITEMS);
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int PAGE_NUM_W   = $clog2(PAGE_COUNT + 1);
    localparam int FILL_W       = $clog2(PAGE_ITEMS + 1);

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;      // write one store position
        logic start;     // latch search key and page geometry
        logic idx_adv;   // index entry passed, move to next page
        logic pg_enter;  // begin scanning the selected page
        logic pg_probe;  // one page entry compared this cycle
        logic hit;       // capture matching payload
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic idx_more;   // current index entry is within range and not above key
        logic page_zero;  // no index entry passed: key below the first page, or no pages in use
        logic key_hit;    // compared page entry equals key
        logic last_slot;  // compared page entry is the last one to test
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== design/iss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module iss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/iss_ctrl.sv =====
// Sequencing FSM for the indexed search: load, index scan, page scan, result.
// Depends on iss_pkg.
`default_nettype none

module iss_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_mode,
    input  wire logic             i_ready,
    input  wire iss_pkg::t_dp_sts i_sts,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output iss_pkg::t_dp_cmd      o_cmd
);
    import iss_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_IDX  = 2'd1;
    localparam logic [1:0] ST_PG   = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_mode == MODE_SEARCH) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_IDX;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_IDX: begin
                if (i_sts.idx_more) begin
                    o_cmd.idx_adv = 1'b1;
                end else if (i_sts.page_zero) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.pg_enter = 1'b1;
                    n_state        = ST_PG;
                end
            end
            ST_PG: begin
                o_cmd.pg_probe = 1'b1;
                if (i_sts.key_hit) begin
                    o_cmd.hit = 1'b1;
                    n_state   = ST_OUT;
                end else if (i_sts.last_slot) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);

endmodule

`default_nettype wire

// ===== design/iss_dp.sv =====
// Datapath for the indexed search: stores, page index, scan counters, result.
// Depends on iss_pkg and iss_ram.
`default_nettype none

module iss_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire iss_pkg::t_dp_cmd              i_cmd,
    input  wire logic                          i_cfg_we,
    input  wire logic [iss_pkg::COUNT_W-1:0]   i_cfg_wdata,
    input  wire logic [iss_pkg::POS_W-1:0]     i_item_position,
    input  wire logic [iss_pkg::KEY_W-1:0]     i_key_ord,
    input  wire logic [iss_pkg::PAYLOAD_BITS-1:0] i_payload,
    output iss_pkg::t_dp_sts                   o_sts,
    output logic                               o_found,
    output logic [iss_pkg::PAYLOAD_BITS-1:0]   o_payload_out,
    output logic [iss_pkg::PROBE_W-1:0]        o_probe_count
);
    import iss_pkg::*;

    logic [COUNT_W-1:0]      r_item_count;
    logic [KEY_W-1:0]        r_key;
    logic [PAGE_NUM_W-1:0]   r_pages_used;
    logic [FILL_W-1:0]       r_last_n;
    logic [PAGE_NUM_W-1:0]   r_page;
    logic [SLOT_W-1:0]       r_j;
    logic [PROBE_W-1:0]      r_probes;
    logic                    r_found;
    logic [PAYLOAD_BITS-1:0] r_payload_out;

    logic [COUNT_W-1:0]      cnt_clamped;
    logic [COUNT_W:0]        cnt_round;
    logic [PAGE_NUM_W-1:0]   page_m1;
    logic [PAGE_NUM_W-1:0]   page_p1;
    logic [SLOT_W-1:0]       j_sel;
    logic [FILL_W-1:0]       page_n;
    logic [FILL_W-1:0]       j_p1;
    logic                    pos_ok;
    logic                    we_store;
    logic                    we_idx;
    logic [PAGE_AW-1:0]      idx_raddr;
    logic [STORE_AW-1:0]     store_raddr;
    logic [KEY_W-1:0]        idx_rdata;
    logic [KEY_W-1:0]        key_rdata;
    logic [PAYLOAD_BITS-1:0] pay_rdata;

    // Geometry of the store as seen by the next search.
    assign cnt_clamped = (r_item_count > COUNT_W'(STORE_DEPTH)) ?
                         COUNT_W'(STORE_DEPTH) : r_item_count;
    assign cnt_round   = {1'b0, cnt_clamped} + (COUNT_W + 1)'(PAGE_ITEMS - 1);

    assign pos_ok   = ({1'b0, i_item_position} < (POS_W + 1)'(STORE_DEPTH));
    assign we_store = i_cmd.load && pos_ok;
    assign we_idx   = we_store && (i_item_position[SLOT_W-1:0] == '0);

    assign page_p1   = r_page + PAGE_NUM_W'(1);
    assign page_m1   = r_page - PAGE_NUM_W'(1);
    assign idx_raddr = i_cmd.idx_adv ? page_p1[PAGE_AW-1:0] : '0;

    assign j_sel       = i_cmd.pg_enter ? '0 : (r_j + SLOT_W'(1));
    assign store_raddr = {page_m1[PAGE_AW-1:0], j_sel};

    assign page_n = (r_page < r_pages_used) ? FILL_W'(PAGE_ITEMS) : r_last_n;
    assign j_p1   = FILL_W'(r_j) + FILL_W'(1);

    iss_ram #(.WIDTH(KEY_W), .DEPTH(PAGE_COUNT)) u_idx_ram (
        .i_clk   (i_clk),
        .i_we    (we_idx),
        .i_waddr (i_item_position[STORE_AW-1:SLOT_W]),
        .i_wdata (i_key_ord),
        .i_raddr (idx_raddr),
        .o_rdata (idx_rdata)
    );

    iss_ram #(.WIDTH(KEY_W), .DEPTH(STORE_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (we_store),
        .i_waddr (i_item_position[STORE_AW-1:0]),
        .i_wdata (i_key_ord),
        .i_raddr (store_raddr),
        .o_rdata (key_rdata)
    );

    iss_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(STORE_DEPTH)) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (we_store),
        .i_waddr (i_item_position[STORE_AW-1:0]),
        .i_wdata (i_payload),
        .i_raddr (store_raddr),
        .o_rdata (pay_rdata)
    );

    always_comb begin
        o_sts           = '0;
        o_sts.idx_more  = (r_page < r_pages_used) && (idx_rdata <= r_key);
        o_sts.page_zero = (r_page == '0);
        o_sts.key_hit   = (key_rdata == r_key);
        o_sts.last_slot = (j_p1 == page_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= '0;
            r_found      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_item_count <= i_cfg_wdata;
            end
            if (i_cmd.start) begin
                r_found <= 1'b0;
            end else if (i_cmd.hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key         <= i_key_ord;
            r_pages_used  <= cnt_round[SLOT_W+PAGE_NUM_W-1:SLOT_W];
            r_last_n      <= (cnt_clamped[SLOT_W-1:0] == '0) ?
                             FILL_W'(PAGE_ITEMS) : FILL_W'(cnt_clamped[SLOT_W-1:0]);
            r_page        <= '0;
            r_probes      <= PROBE_W'(1);
            r_payload_out <= '0;
        end else begin
            if (i_cmd.idx_adv) begin
                r_page <= page_p1;
            end
            if (i_cmd.idx_adv || i_cmd.pg_probe) begin
                r_probes <= r_probes + PROBE_W'(1);
            end
            if (i_cmd.hit) begin
                r_payload_out <= pay_rdata;
            end
        end
        if (i_cmd.pg_enter) begin
            r_j <= '0;
        end else if (i_cmd.pg_probe) begin
            r_j <= r_j + SLOT_W'(1);
        end
    end

    assign o_found       = r_found;
    assign o_payload_out = r_payload_out;
    assign o_probe_count = r_probes;

endmodule

`default_nettype wire

// ===== design/indexed_sequential_search.sv =====
// Top level of the indexed sequential search block.
// Depends on iss_pkg, iss_ctrl, iss_dp (and iss_ram through iss_dp).
`default_nettype none

// Indexed sequential search over a key-sorted store of 256 pages of 4 items,
// each item a signed 32-bit key and a 32-bit payload, with a page index
// holding each page's first key. A load (mode 0) writes key and payload at
// i_item_position and, at a page's first position, that page's index entry;
// it produces no result transfer. A search (mode 1) walks the index for the
// last page whose first key is not above the search key, bounded by the
// pages in use given by item_count, then compares that page's entries (a
// short last page holds item_count mod 4 items) and returns found, the
// payload (zero on a miss) and the number of key comparisons. Timing: one
// item in flight at a time. A search passes up to 256 index entries and
// compares up to 4 page entries before its result is offered. The result
// then stays on offer until taken and the next item is taken from the cycle
// after the result transfer. The search time is set by the index and page
// walks, one RAM read per cycle on the single read port of each store.
// Stores and index are not cleared at reset: a search must only reach
// entries that have been loaded. item_count is written through i_cfg_we /
// i_cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce. Values above 1024 act as 1024.

module indexed_sequential_search (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic                               i_mode,
    input  wire logic [iss_pkg::POS_W-1:0]          i_item_position,
    input  wire logic signed [iss_pkg::KEY_W-1:0]   i_key,
    input  wire logic [iss_pkg::PAYLOAD_BITS-1:0]   i_payload,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic                                    o_found,
    output logic [iss_pkg::PAYLOAD_BITS-1:0]        o_payload_out,
    output logic [iss_pkg::PROBE_W-1:0]             o_probe_count,
    input  wire logic                               i_cfg_we,
    input  wire logic [iss_pkg::COUNT_W-1:0]        i_cfg_wdata
);
    import iss_pkg::*;

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [KEY_W-1:0]  key_ord;

    // Sign bit flipped so plain unsigned compares give signed key order.
    assign key_ord = {~i_key[KEY_W-1], i_key[KEY_W-2:0]};

    iss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_mode      (i_mode),
        .i_ready     (i_ready),
        .i_sts       (sts),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    iss_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_item_position (i_item_position),
        .i_key_ord       (key_ord),
        .i_payload       (i_payload),
        .o_sts           (sts),
        .o_found         (o_found),
        .o_payload_out   (o_payload_out),
        .o_probe_count   (o_probe_count)
    );

    // A result on offer means no input transfer can be taken.
    a_busy_when_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while result offered");

    // A miss always reports a zero payload.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_payload_out == '0))
        else $error("non-zero payload on miss");

    // Every search makes at least the first index comparison.
    a_probe_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_probe_count != '0))
        else $error("zero probe count");

    // A load never produces a result transfer.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_mode == MODE_LOAD)) |=> !o_valid)
        else $error("result after load");

endmodule

`default_nettype wire

// ===== tb/search_checker.sv =====
// Scoreboard for the indexed sequential search block: watches the item, result
// and item_count ports, predicts each search result and compares it per field.
// Depends on iss_pkg for the store geometry and field widths.

module search_checker (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    input  wire logic                                   i_in_ready,
    input  wire logic                                   i_mode,
    input  wire logic [iss_pkg::POS_W-1:0]              i_position,
    input  wire logic signed [iss_pkg::KEY_W-1:0]       i_key,
    input  wire logic [iss_pkg::PAYLOAD_BITS-1:0]       i_payload,
    input  wire logic                                   i_out_valid,
    input  wire logic                                   i_out_ready,
    input  wire logic                                   i_found,
    input  wire logic [iss_pkg::PAYLOAD_BITS-1:0]       i_payload_out,
    input  wire logic [iss_pkg::PROBE_W-1:0]            i_probe_count,
    input  wire logic                                   i_cfg_we,
    input  wire logic [iss_pkg::COUNT_W-1:0]            i_cfg_wdata,
    output int                                          o_faults,
    output int                                          o_pending,
    output int                                          o_results,
    output int                                          o_hits
);

    localparam int DEPTH     = iss_pkg::STORE_DEPTH;
    localparam int PER_PAGE  = iss_pkg::PAGE_ITEMS;
    localparam int PROBE_MAX = (1 << iss_pkg::PROBE_W) - 1;

    typedef struct packed {
        logic                               found;
        logic [iss_pkg::PAYLOAD_BITS-1:0]   payload;
        logic [iss_pkg::PROBE_W-1:0]        probes;
    } t_lookup;

    logic signed [iss_pkg::KEY_W-1:0]   key_mem     [DEPTH];
    logic [iss_pkg::PAYLOAD_BITS-1:0]   payload_mem [DEPTH];
    logic signed [iss_pkg::KEY_W-1:0]   first_key   [iss_pkg::PAGE_COUNT];
    logic [iss_pkg::COUNT_W-1:0]        item_total;

    t_lookup awaited_q [$];
    int      fault_total;
    int      result_total;
    int      hit_total;

    // index walk then page walk, counting every key comparison
    function automatic t_lookup look_up(input logic signed [iss_pkg::KEY_W-1:0] wanted);
        t_lookup r;
        int      used;
        int      pages;
        int      pg;
        int      span;
        int      probes;
        r      = '0;
        used   = (int'(item_total) > DEPTH) ? DEPTH : int'(item_total);
        pages  = (used + PER_PAGE - 1) / PER_PAGE;
        probes = 1;
        pg     = 0;
        while (pg < pages && first_key[pg] <= wanted) begin
            probes++;
            pg++;
        end
        if (pg != 0) begin
            if (pg < pages) begin
                span = PER_PAGE;
            end else begin
                span = used % PER_PAGE;
                if (span == 0) span = PER_PAGE;
            end
            for (int j = 0; j < span && !r.found; j++) begin
                probes++;
                if (key_mem[(pg - 1) * PER_PAGE + j] == wanted) begin
                    r.found   = 1'b1;
                    r.payload = payload_mem[(pg - 1) * PER_PAGE + j];
                end
            end
        end
        if (probes > PROBE_MAX) probes = PROBE_MAX;
        r.probes = probes[iss_pkg::PROBE_W-1:0];
        return r;
    endfunction

    task automatic note_fault(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fault_total++;
    endtask

    always @(posedge i_clk) begin : track
        t_lookup want;
        if (!i_rst_n) begin
            awaited_q.delete();
            item_total   = '0;
            fault_total  = 0;
            result_total = 0;
            hit_total    = 0;
        end else begin
            if (i_cfg_we) item_total = i_cfg_wdata;
            if (i_out_valid && i_out_ready) begin
                if (awaited_q.size() == 0) begin
                    note_fault("result transfer with no search outstanding");
                end else begin
                    want = awaited_q.pop_front();
                    result_total++;
                    if (want.found) hit_total++;
                    if (i_found !== want.found)
                        note_fault($sformatf("found %0b, predicted %0b", i_found, want.found));
                    if (i_payload_out !== want.payload)
                        note_fault($sformatf("payload %h, predicted %h",
                                             i_payload_out, want.payload));
                    if (i_probe_count !== want.probes)
                        note_fault($sformatf("probe count %0d, predicted %0d",
                                             i_probe_count, want.probes));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_mode == iss_pkg::MODE_LOAD) begin
                    if (int'(i_position) < DEPTH) begin
                        key_mem[i_position]     = i_key;
                        payload_mem[i_position] = i_payload;
                        if (i_position % PER_PAGE == 0)
                            first_key[i_position / PER_PAGE] = i_key;
                    end
                end else begin
                    awaited_q.push_back(look_up(i_key));
                end
            end
        end
        o_faults  <= fault_total;
        o_pending <= awaited_q.size();
        o_results <= result_total;
        o_hits    <= hit_total;
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the indexed sequential search testbench: clock, reset, item and
// item_count stimulus, receiver stalls and the verdict.
// Depends on iss_pkg, indexed_sequential_search and search_checker.

module testbench;

    localparam int DEPTH = iss_pkg::STORE_DEPTH;
    // keys of a fresh fill climb by this much per position, so the whole
    // signed range is spread across the store in order
    localparam logic [31:0] KEY_STRIDE = 32'h1 << (32 - $clog2(iss_pkg::STORE_DEPTH));
    localparam int SETTLE_CYCLES = 300;   // longer than the slowest search

    typedef enum int {PACE_FREE, PACE_SLOW_SEND, PACE_SLOW_TAKE, PACE_BOTH} t_pace;

    logic                                   clk         = 1'b0;
    logic                                   rst_n       = 1'b0;
    logic                                   in_valid    = 1'b0;
    logic                                   in_ready;
    logic                                   in_mode     = iss_pkg::MODE_LOAD;
    logic [iss_pkg::POS_W-1:0]              in_position = '0;
    logic signed [iss_pkg::KEY_W-1:0]       in_key      = '0;
    logic [iss_pkg::PAYLOAD_BITS-1:0]       in_payload  = '0;
    logic                                   out_valid;
    logic                                   out_ready   = 1'b0;
    logic                                   out_found;
    logic [iss_pkg::PAYLOAD_BITS-1:0]       out_payload;
    logic [iss_pkg::PROBE_W-1:0]            out_probes;
    logic                                   cfg_we      = 1'b0;
    logic [iss_pkg::COUNT_W-1:0]            cfg_wdata   = '0;

    int faults;
    int pending;
    int results;
    int hits;

    // idle percentages for the current phase
    int send_idle_pct  = 0;
    int take_stall_pct = 0;

    // what has been written to the store, kept only to steer the stimulus
    logic [31:0] shadow_key [DEPTH];
    bit          loaded     [DEPTH];

    int loads_sent    = 0;
    int searches_sent = 0;
    int phases_run    = 0;

    // item_count per random phase: tiny stores, short last pages, page edges,
    // the full store and values past it, then empty again
    int phase_sizes [14] = '{1, 4, 5, 2, 17, 63, 64, 130, 1024, 2047, 1025, 255, 12, 0};

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    indexed_sequential_search i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_mode          (in_mode),
        .i_item_position (in_position),
        .i_key           (in_key),
        .i_payload       (in_payload),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_found         (out_found),
        .o_payload_out   (out_payload),
        .o_probe_count   (out_probes),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    search_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_mode        (in_mode),
        .i_position    (in_position),
        .i_key         (in_key),
        .i_payload     (in_payload),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_found       (out_found),
        .i_payload_out (out_payload),
        .i_probe_count (out_probes),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_faults      (faults),
        .o_pending     (pending),
        .o_results     (results),
        .o_hits        (hits)
    );

    // receiver: stalls at random in the proportion the phase asks for
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= take_stall_pct);
    end

    // hard stop should the block hang
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_FREE: begin
                send_idle_pct  = 0;
                take_stall_pct = 0;
            end
            PACE_SLOW_SEND: begin
                send_idle_pct  = 75;
                take_stall_pct = 0;
            end
            PACE_SLOW_TAKE: begin
                send_idle_pct  = 0;
                take_stall_pct = 75;
            end
            default: begin
                send_idle_pct  = 20;
                take_stall_pct = 20;
            end
        endcase
    endtask

    // One item transfer. Called at the edge that took the previous item, so
    // valid is either held high for back-to-back transfers or dropped for a
    // random gap - never both in the same step.
    task automatic push_item(input logic mode, input logic [iss_pkg::POS_W-1:0] pos,
                             input logic [31:0] k, input logic [31:0] pay);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        in_mode     <= mode;
        in_position <= pos;
        in_key      <= k;
        in_payload  <= pay;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic load_entry(input int pos, input logic [31:0] k, input logic [31:0] pay);
        shadow_key[pos] = k;
        loaded[pos]     = 1'b1;
        loads_sent++;
        push_item(iss_pkg::MODE_LOAD, iss_pkg::POS_W'(pos), k, pay);
    endtask

    // position and payload mean nothing to a search; random values all the same
    task automatic search_for(input logic [31:0] k);
        searches_sent++;
        push_item(iss_pkg::MODE_SEARCH, iss_pkg::POS_W'($urandom_range(DEPTH - 1)), k,
                  $urandom);
    endtask

    // Sender stops until every search result has been transferred. The
    // pending count is registered, so it is first read after the next edge.
    task automatic hold_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // a load leaves nothing to wait on, so allow for the slowest item too
    task automatic settle();
        hold_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input int value);
        cfg_wdata <= iss_pkg::COUNT_W'(value);
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // ascending key for a fresh fill, now and then at the bottom or top of
    // its slice so the signed extremes turn up
    function automatic logic [31:0] ordered_key(input int pos);
        logic [31:0] spread;
        int          roll;
        roll = $urandom_range(7);
        if (roll == 0)      spread = '0;
        else if (roll == 1) spread = KEY_STRIDE - 1;
        else                spread = $urandom_range(KEY_STRIDE - 1);
        return 32'h8000_0000 + 32'(pos) * KEY_STRIDE + spread;
    endfunction

    // Every position the index and page walks can reach must hold data
    // before a search is allowed to run against this item_count.
    task automatic fill_below(input int used);
        for (int p = 0; p < used; p++)
            if (!loaded[p]) load_entry(p, ordered_key(p), $urandom);
    endtask

    // Mostly stored keys (hits), some off by one (near misses inside a page),
    // some anywhere, a few at the very ends of the key range.
    function automatic logic [31:0] probe_key(input int used);
        logic [31:0] k;
        int          roll;
        roll = $urandom_range(99);
        if (used == 0 || roll < 15) begin
            k = $urandom;
        end else if (roll < 20) begin
            k = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            k = shadow_key[$urandom_range(used - 1)];
            if (roll < 40) k = k + ($urandom_range(1) ? 32'h1 : 32'hffff_ffff);
        end
        return k;
    endfunction

    // Noise: rewrites payloads, copies a neighbour's key (duplicates) or
    // drops a random key into the sorted run, which breaks the ordering.
    task automatic stray_load(input int used);
        int          pos;
        int          roll;
        logic [31:0] k;
        pos  = ($urandom_range(1) && used > 0) ? $urandom_range(used - 1)
                                               : $urandom_range(DEPTH - 1);
        roll = $urandom_range(3);
        if (!loaded[pos])           k = ordered_key(pos);
        else if (roll < 2)          k = shadow_key[pos];
        else if (roll == 2 && pos > 0 && loaded[pos - 1]) k = shadow_key[pos - 1];
        else                        k = $urandom;
        load_entry(pos, k, $urandom);
    endtask

    task automatic run_phase(input int count_value, input t_pace pace, input int searches);
        int used;
        used = (count_value > DEPTH) ? DEPTH : count_value;
        settle();
        write_count(count_value);
        set_pace(pace);
        fill_below(used);
        for (int s = 0; s < searches; s++) begin
            // at mid-phase the sender waits for the block to empty
            if (s == searches / 2) hold_for_results();
            if ($urandom_range(9) == 0) stray_load(used);
            search_for(probe_key(used));
        end
        phases_run++;
    endtask

    initial begin : stimulus
        logic [31:0] first_keys  [6];
        logic [31:0] first_loads [6];
        first_keys  = '{32'hffff_fc18, 32'hffff_ff9c, 32'hffff_ffff, 32'h0000_0000,
                        32'h0000_0064, 32'h7fff_ffff};
        first_loads = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
                        32'h1234_5678, 32'h5a5a_a5a5};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store straight after reset, then a two-page store
        // of six items whose last page is short
        set_pace(PACE_FREE);
        search_for(32'h0000_0000);
        for (int p = 0; p < 6; p++) load_entry(p, first_keys[p], first_loads[p]);
        settle();
        write_count(6);
        search_for(32'h8000_0000);      // below the first page
        search_for(32'hffff_fc18);      // first key of the first page
        search_for(32'hffff_ffff);      // inside the first page
        search_for(32'h0000_0032);      // miss, whole first page scanned
        search_for(32'h0000_0064);      // first key of the short last page
        search_for(32'h7fff_ffff);      // top key, end of the short page
        search_for(32'h7fff_fffe);      // miss in the short page
        phases_run++;

        // let the random fills lay down an ordered run from position 0
        for (int p = 0; p < 6; p++) loaded[p] = 1'b0;

        for (int i = 0; i < 14; i++) run_phase(phase_sizes[i], t_pace'(i % 4), 20);

        settle();

        $display("Run covered %0d loads and %0d searches (%0d hits, %0d results checked)",
                 loads_sent, searches_sent, hits, results);
        $display("over %0d item_count settings from 0 to past the store size, with idling.",
                 phases_run);
        if (faults == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
